### design/mrm_pkg.sv
// Shared types, codes and helpers of the Modbus RTU master engine.
// No dependencies; compile this file first.
package mrm_pkg;

    // Default sizes of the buffers and the timeout after reset.
    localparam int BUF_WORDS_DEF   = 64;
    localparam int FRAME_BYTES_DEF = 256;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    // CRC16 for Modbus: reflected polynomial, preset all ones.
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Host operations.
    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_FETCH = 3'd2;
    localparam logic [2:0] OP_RX    = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    // Result kinds.
    localparam logic [1:0] RK_LOAD = 2'd0;
    localparam logic [1:0] RK_TX   = 2'd1;
    localparam logic [1:0] RK_DONE = 2'd2;
    localparam logic [1:0] RK_WORD = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SLAVE   = 3'd1;
    localparam logic [2:0] ST_FUNC    = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_CRC     = 3'd4;
    localparam logic [2:0] ST_INDEX   = 3'd5;
    localparam logic [2:0] ST_EXC     = 3'd6;
    localparam logic [2:0] ST_OVER    = 3'd7;

    // Modbus function codes that the engine knows.
    localparam logic [7:0] FC_RD_COILS   = 8'd1;
    localparam logic [7:0] FC_RD_INPUTS  = 8'd2;
    localparam logic [7:0] FC_RD_HOLDING = 8'd3;
    localparam logic [7:0] FC_RD_INREGS  = 8'd4;
    localparam logic [7:0] FC_WR_COIL    = 8'd5;
    localparam logic [7:0] FC_WR_REG     = 8'd6;
    localparam logic [7:0] FC_WR_COILS   = 8'd15;
    localparam logic [7:0] FC_WR_REGS    = 8'd16;
    localparam logic [7:0] FC_MASK_WR    = 8'd22;
    localparam logic [7:0] FC_RDWR_REGS  = 8'd23;

    // One host request.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  slave_id;
        logic [7:0]  func_code;
        logic [15:0] read_start;
        logic [15:0] read_count;
        logic [15:0] write_start;
        logic [15:0] write_count;
        logic [7:0]  word_index;
        logic [15:0] word_data;
        logic [7:0]  rx_data;
        logic        is_read_word;
    } in_t;

    // One result.
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  tx_data;
        logic        last_byte;
        logic [2:0]  status;
        logic [7:0]  exception_code;
        logic [15:0] resp_word;
        logic [7:0]  resp_length;
    } out_t;

    // True for functions whose request carries a read address and quantity.
    function automatic logic is_read_fc(input logic [7:0] f);
        return (f == FC_RD_COILS) || (f == FC_RD_INPUTS) || (f == FC_RD_HOLDING) ||
               (f == FC_RD_INREGS) || (f == FC_RDWR_REGS);
    endfunction

    // Folds one byte into the CRC, one bit per step.
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

### design/mrm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; read data holds until the next read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/modbus_rtu_master_engine.sv
// Modbus RTU master engine: request framing, CRC16, response checking and unpacking.
// Depends on mrm_pkg and mrm_ram.
//
// Usage: the host sends operations on the s_ channel (valid/ready, one mrm_pkg::in_t
// per transaction). Load transmit words, start a request, then fetch the request frame
// one byte per transaction until last_byte is set; the CRC is appended. Received
// bytes are fed back as rx operations, millisecond ticks drive the timeout, and the
// unpacked response words are read back by index. Results leave on the m_ channel
// (one mrm_pkg::out_t per transaction); some operations give no result.
// The timeout register is written over cfg_valid/cfg_ready/cfg_data, which is always
// ready. The accept cycle issues the buffer read and registers the operation, which
// then executes with the registered read data; no further operation is taken until
// it has executed. The final byte of a good read response is followed by an unpack
// pass over the stored frame, two frame RAM reads and one word write per response
// word, during which no operation is accepted.
// After reset the engine is idle, the timeout is 2000 and no response words are
// valid; no clearing pass is run. A stalled receiver holds the result register and
// one further operation may be accepted, which then waits until the result is taken.
module modbus_rtu_master_engine #(
    parameter int BUF_WORDS   = mrm_pkg::BUF_WORDS_DEF,
    parameter int FRAME_BYTES = mrm_pkg::FRAME_BYTES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mrm_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mrm_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data
);
    import mrm_pkg::*;

    localparam int BW = $clog2(BUF_WORDS);
    localparam int LW = $clog2(BUF_WORDS + 1);
    localparam int FA = $clog2(FRAME_BYTES);
    localparam int PW = ($clog2(FRAME_BYTES + 1) > 9) ? $clog2(FRAME_BYTES + 1) : 9;

    typedef enum logic [1:0] {PH_IDLE, PH_SEND, PH_RECV} phase_t;
    typedef enum logic [2:0] {UP_IDLE, UP_RA, UP_RB, UP_WR, UP_OW, UP_DONE} up_t;

    // Registers.
    phase_t         phase_reg, phase_next;
    up_t            up_reg, up_next;
    logic           e_valid_reg, e_valid_next;
    in_t            e_reg;
    in_t            rq_reg, rq_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [15:0]    crc_reg, crc_next;
    logic [8:0]     rem_reg, rem_next;
    logic [15:0]    ela_reg, ela_next;
    logic [15:0]    tmo_reg;
    logic [7:0]     len_reg, len_next;
    logic [7:0]     b1_reg, b1_next, b2_reg, b2_next;
    logic [7:0]     r0_reg, r0_next, r1_reg, r1_next, r2_reg, r2_next;
    logic [LW-1:0]  ui_reg, ui_next, unw_reg, unw_next;
    logic [7:0]     ub_reg, ub_next, ulen_reg, ulen_next;
    logic           uodd_reg, uodd_next, ucoil_reg, ucoil_next;
    logic           m_valid_reg;
    out_t           m_data_reg;

    // RAM ports.
    logic           tx_we, tx_re;
    logic [BW-1:0]  tx_raddr;
    logic [15:0]    tx_rdata;
    logic           rs_we, rs_re;
    logic [BW-1:0]  rs_waddr;
    logic [15:0]    rs_wdata, rs_rdata;
    logic           rx_we, rx_re;
    logic [FA-1:0]  rx_waddr, rx_raddr;
    logic [7:0]     rx_rdata;

    // Frame head decode.
    logic [7:0]     hb [16];
    logic [3:0]     hl;
    logic           dcoil;
    logic [8:0]     dbytes;
    logic [PW-1:0]  body;
    logic [16:0]    wsum;
    logic [13:0]    q15;
    logic [8:0]     q15c;
    logic [7:0]     q16;
    logic [PW-1:0]  dpos;

    // Execute.
    logic           accept, out_free, ex_fin, has_res;
    out_t           res;
    logic [7:0]     tbyte;
    logic [15:0]    crc_c, ela_c;
    logic [8:0]     rem_c;
    logic [PW-1:0]  np;
    logic           failed;
    logic [7:0]     un8;

    assign cfg_ready = 1'b1;
    assign s_ready   = !e_valid_reg;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Buffers.
    mrm_ram #(.WIDTH(16), .DEPTH(BUF_WORDS)) u_tx_ram (
        .aclk(aclk), .we(tx_we), .waddr(e_reg.word_index[BW-1:0]), .wdata(e_reg.word_data),
        .re(tx_re), .raddr(tx_raddr), .rdata(tx_rdata)
    );
    mrm_ram #(.WIDTH(16), .DEPTH(BUF_WORDS)) u_resp_ram (
        .aclk(aclk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
        .re(rs_re), .raddr(s_data.word_index[BW-1:0]), .rdata(rs_rdata)
    );
    mrm_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_rx_ram (
        .aclk(aclk), .we(rx_we), .waddr(rx_waddr), .wdata(e_reg.rx_data),
        .re(rx_re), .raddr(rx_raddr), .rdata(rx_rdata)
    );

    // Request frame head, data kind and data length from the stored request.
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            hb[k] = 8'h00;
        end
        wsum   = {1'b0, rq_reg.write_count} + 17'd7;
        q15    = wsum[16:3];
        q15c   = (q15 > 14'(2 * BUF_WORDS)) ? 9'(2 * BUF_WORDS) : q15[8:0];
        q16    = (rq_reg.write_count > 16'(BUF_WORDS)) ? 8'(BUF_WORDS)
                                                        : rq_reg.write_count[7:0];
        hb[0]  = rq_reg.slave_id;
        hb[1]  = rq_reg.func_code;
        hl     = 4'd2;
        dcoil  = 1'b0;
        dbytes = 9'd0;
        case (rq_reg.func_code) inside
            FC_RD_COILS, FC_RD_INPUTS, FC_RD_HOLDING, FC_RD_INREGS: begin
                hb[2] = rq_reg.read_start[15:8];
                hb[3] = rq_reg.read_start[7:0];
                hb[4] = rq_reg.read_count[15:8];
                hb[5] = rq_reg.read_count[7:0];
                hl    = 4'd6;
            end
            FC_WR_COIL: begin
                hb[2] = rq_reg.write_start[15:8];
                hb[3] = rq_reg.write_start[7:0];
                hb[4] = (rq_reg.write_count != 16'd0) ? 8'hFF : 8'h00;
                hl    = 4'd6;
            end
            FC_WR_REG, FC_MASK_WR: begin
                hb[2]  = rq_reg.write_start[15:8];
                hb[3]  = rq_reg.write_start[7:0];
                hl     = 4'd4;
                dbytes = (rq_reg.func_code == FC_WR_REG) ? 9'd2 : 9'd4;
            end
            FC_WR_COILS, FC_WR_REGS: begin
                hb[2]  = rq_reg.write_start[15:8];
                hb[3]  = rq_reg.write_start[7:0];
                hb[4]  = rq_reg.write_count[15:8];
                hb[5]  = rq_reg.write_count[7:0];
                hl     = 4'd7;
                dcoil  = (rq_reg.func_code == FC_WR_COILS);
                dbytes = dcoil ? q15c : {q16, 1'b0};
                hb[6]  = dbytes[7:0];
            end
            FC_RDWR_REGS: begin
                hb[2]  = rq_reg.read_start[15:8];
                hb[3]  = rq_reg.read_start[7:0];
                hb[4]  = rq_reg.read_count[15:8];
                hb[5]  = rq_reg.read_count[7:0];
                hb[6]  = rq_reg.write_start[15:8];
                hb[7]  = rq_reg.write_start[7:0];
                hb[8]  = rq_reg.write_count[15:8];
                hb[9]  = rq_reg.write_count[7:0];
                dbytes = {q16, 1'b0};
                hb[10] = dbytes[7:0];
                hl     = 4'd11;
            end
            default: begin
                hl = 4'd2;
            end
        endcase
        body = PW'(hl) + PW'(dbytes);
        dpos = pos_reg - PW'(hl);
    end

    // Buffer reads issued at accept time.
    always_comb begin
        tx_re    = accept && (s_data.opcode == OP_FETCH);
        tx_raddr = dpos[BW:1];
        rs_re    = accept && (s_data.opcode == OP_TICK) && s_data.is_read_word &&
                   (s_data.word_index < 8'(BUF_WORDS));
    end

    // Execute stage and unpack sequencer.
    always_comb begin
        phase_next = phase_reg;
        up_next    = up_reg;
        rq_next    = rq_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        rem_next   = rem_reg;
        ela_next   = ela_reg;
        len_next   = len_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        r2_next    = r2_reg;
        ui_next    = ui_reg;
        unw_next   = unw_reg;
        ub_next    = ub_reg;
        ulen_next  = ulen_reg;
        uodd_next  = uodd_reg;
        ucoil_next = ucoil_reg;
        res        = '0;
        has_res    = 1'b0;
        ex_fin     = 1'b0;
        tx_we      = 1'b0;
        rs_we      = 1'b0;
        rs_waddr   = ui_reg[BW-1:0];
        rs_wdata   = 16'h0000;
        rx_we      = 1'b0;
        rx_waddr   = pos_reg[FA-1:0];
        rx_re      = 1'b0;
        rx_raddr   = FA'({ui_reg, 1'b0}) + FA'(3);
        tbyte      = 8'h00;
        crc_c      = crc_reg;
        ela_c      = ela_reg;
        rem_c      = rem_reg;
        np         = pos_reg + PW'(1);
        failed     = 1'b0;
        un8        = {1'b0, r2_reg[7:1]};

        if (e_valid_reg && (up_reg == UP_IDLE) && out_free) begin
            ex_fin = 1'b1;
            case (e_reg.opcode)
                OP_LOAD: begin
                    has_res = 1'b1;
                    res.result_kind = RK_LOAD;
                    if (e_reg.word_index < 8'(BUF_WORDS)) begin
                        tx_we = 1'b1;
                    end else begin
                        res.status = ST_INDEX;
                    end
                end
                OP_START: begin
                    rq_next    = e_reg;
                    pos_next   = '0;
                    crc_next   = CRC_INIT;
                    rem_next   = 9'd8;
                    ela_next   = 16'd0;
                    phase_next = PH_SEND;
                end
                OP_FETCH: begin
                    if (phase_reg == PH_SEND) begin
                        has_res = 1'b1;
                        res.result_kind = RK_TX;
                        // Head byte, data byte from the transmit buffer, or CRC.
                        if (pos_reg < PW'(hl)) begin
                            tbyte = hb[pos_reg[3:0]];
                        end else if (dcoil) begin
                            tbyte = dpos[0] ? tx_rdata[15:8] : tx_rdata[7:0];
                        end else begin
                            tbyte = dpos[0] ? tx_rdata[7:0] : tx_rdata[15:8];
                        end
                        if (pos_reg < body) begin
                            crc_next = crc_byte(crc_reg, tbyte);
                        end else if (pos_reg == body) begin
                            tbyte = crc_reg[7:0];
                        end else begin
                            tbyte = crc_reg[15:8];
                        end
                        res.tx_data = tbyte;
                        if (pos_reg >= body + PW'(1)) begin
                            res.last_byte = 1'b1;
                            phase_next    = PH_RECV;
                            pos_next      = '0;
                            crc_next      = CRC_INIT;
                            rem_next      = 9'd8;
                            ela_next      = 16'd0;
                        end else begin
                            pos_next = np;
                        end
                    end
                end
                OP_RX: begin
                    if (phase_reg == PH_RECV) begin
                        if (pos_reg >= PW'(FRAME_BYTES)) begin
                            has_res = 1'b1;
                            res.status = ST_OVER;
                        end else begin
                            // The CRC trails the frame by two bytes.
                            if (pos_reg >= PW'(2)) begin
                                crc_c = crc_byte(crc_reg, b2_reg);
                            end
                            crc_next = crc_c;
                            rx_we    = 1'b1;
                            b2_next  = b1_reg;
                            b1_next  = e_reg.rx_data;
                            if (pos_reg == PW'(0)) begin
                                r0_next = e_reg.rx_data;
                            end
                            if (pos_reg == PW'(1)) begin
                                r1_next = e_reg.rx_data;
                            end
                            if (pos_reg == PW'(2)) begin
                                r2_next = e_reg.rx_data;
                            end
                            pos_next = np;
                            if (rem_reg != 9'd0) begin
                                rem_c = rem_reg - 9'd1;
                            end
                            // Header check once the first five bytes are in.
                            if (np == PW'(5)) begin
                                if (r0_reg != rq_reg.slave_id) begin
                                    failed = 1'b1;
                                    res.status = ST_SLAVE;
                                end else if ({1'b0, r1_reg[6:0]} != rq_reg.func_code) begin
                                    failed = 1'b1;
                                    res.status = ST_FUNC;
                                end else if (r1_reg[7]) begin
                                    failed = 1'b1;
                                    res.status = ST_EXC;
                                    res.exception_code = r2_reg;
                                end else if (is_read_fc(rq_reg.func_code)) begin
                                    rem_c = {1'b0, r2_reg};
                                end else if (rq_reg.func_code == FC_MASK_WR) begin
                                    rem_c = 9'd5;
                                end else begin
                                    rem_c = 9'd3;
                                end
                            end
                            rem_next = rem_c;
                            if (failed) begin
                                has_res = 1'b1;
                            end else if (rem_c == 9'd0) begin
                                if ((crc_c[7:0] != b1_reg) || (crc_c[15:8] != e_reg.rx_data)) begin
                                    has_res = 1'b1;
                                    res.status = ST_CRC;
                                end else if ((r1_reg == FC_RD_COILS) || (r1_reg == FC_RD_INPUTS) ||
                                             (r1_reg == FC_RD_HOLDING) ||
                                             (r1_reg == FC_RD_INREGS) ||
                                             (r1_reg == FC_RDWR_REGS)) begin
                                    // Good read response: unpack before reporting.
                                    ex_fin     = 1'b0;
                                    phase_next = PH_IDLE;
                                    ucoil_next = (r1_reg == FC_RD_COILS) ||
                                                 (r1_reg == FC_RD_INPUTS);
                                    unw_next   = (un8 < 8'(BUF_WORDS)) ? LW'(un8)
                                                                       : LW'(BUF_WORDS);
                                    uodd_next  = ucoil_next && r2_reg[0] &&
                                                 (un8 < 8'(BUF_WORDS));
                                    if (ucoil_next && r2_reg[0]) begin
                                        ulen_next = ((un8 + 8'd1) > 8'(BUF_WORDS))
                                                    ? 8'(BUF_WORDS) : (un8 + 8'd1);
                                    end else begin
                                        ulen_next = (un8 > 8'(BUF_WORDS)) ? 8'(BUF_WORDS)
                                                                          : un8;
                                    end
                                    ui_next = '0;
                                    up_next = UP_RA;
                                end else begin
                                    has_res = 1'b1;
                                    res.status = ST_OK;
                                end
                            end
                        end
                        if (has_res) begin
                            phase_next = PH_IDLE;
                            res.result_kind = RK_DONE;
                            res.resp_length = len_reg;
                        end
                    end
                end
                OP_TICK: begin
                    if (e_reg.is_read_word) begin
                        has_res = 1'b1;
                        res.result_kind = RK_WORD;
                        res.resp_length = len_reg;
                        if (e_reg.word_index < 8'(BUF_WORDS)) begin
                            res.resp_word = rs_rdata;
                        end else begin
                            res.resp_word = 16'hFFFF;
                            res.status = ST_INDEX;
                        end
                    end else if (phase_reg == PH_RECV) begin
                        if (ela_reg != 16'hFFFF) begin
                            ela_c = ela_reg + 16'd1;
                        end
                        ela_next = ela_c;
                        if (ela_c > tmo_reg) begin
                            has_res = 1'b1;
                            phase_next = PH_IDLE;
                            res.result_kind = RK_DONE;
                            res.status = ST_TIMEOUT;
                            res.resp_length = len_reg;
                        end
                    end
                end
                default: begin
                    has_res = 1'b0;
                end
            endcase
        end

        // Unpack pass: two frame reads and one word write per response word.
        case (up_reg)
            UP_IDLE: begin
                // No pass running; the execute stage decides whether one starts.
            end
            UP_RA: begin
                if (ui_reg < unw_reg) begin
                    rx_re   = 1'b1;
                    up_next = UP_RB;
                end else if (uodd_reg) begin
                    rx_re    = 1'b1;
                    rx_raddr = FA'(r2_reg) + FA'(2);
                    up_next  = UP_OW;
                end else begin
                    up_next = UP_DONE;
                end
            end
            UP_RB: begin
                rx_re    = 1'b1;
                rx_raddr = FA'({ui_reg, 1'b0}) + FA'(4);
                ub_next  = rx_rdata;
                up_next  = UP_WR;
            end
            UP_WR: begin
                rs_we    = 1'b1;
                rs_wdata = ucoil_reg ? {rx_rdata, ub_reg} : {ub_reg, rx_rdata};
                ui_next  = ui_reg + LW'(1);
                up_next  = UP_RA;
            end
            UP_OW: begin
                rs_we    = 1'b1;
                rs_waddr = un8[BW-1:0];
                rs_wdata = {8'h00, rx_rdata};
                up_next  = UP_DONE;
            end
            UP_DONE: begin
                if (out_free) begin
                    len_next        = ulen_reg;
                    has_res         = 1'b1;
                    ex_fin          = 1'b1;
                    res.result_kind = RK_DONE;
                    res.status      = ST_OK;
                    res.resp_length = ulen_reg;
                    up_next         = UP_IDLE;
                end
            end
            default: begin
                up_next = UP_IDLE;
            end
        endcase
    end

    // State, configuration and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            up_reg      <= UP_IDLE;
            e_valid_reg <= 1'b0;
            rq_reg      <= '0;
            pos_reg     <= '0;
            crc_reg     <= CRC_INIT;
            rem_reg     <= 9'd8;
            ela_reg     <= 16'd0;
            tmo_reg     <= TIMEOUT_RESET;
            len_reg     <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            up_reg    <= up_next;
            rq_reg    <= rq_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            rem_reg   <= rem_next;
            ela_reg   <= ela_next;
            len_reg   <= len_next;
            if (cfg_valid && cfg_ready) begin
                tmo_reg <= cfg_data;
            end
            if (accept) begin
                e_valid_reg <= 1'b1;
            end else if (ex_fin) begin
                e_valid_reg <= 1'b0;
            end
            if (ex_fin && has_res) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            e_reg <= s_data;
        end
        if (ex_fin && has_res) begin
            m_data_reg <= res;
        end
        b1_reg    <= b1_next;
        b2_reg    <= b2_next;
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        r2_reg    <= r2_next;
        ui_reg    <= ui_next;
        unw_reg   <= unw_next;
        ub_reg    <= ub_next;
        ulen_reg  <= ulen_next;
        uodd_reg  <= uodd_next;
        ucoil_reg <= ucoil_next;
    end

    // The unpack pass always belongs to a held receive operation.
    a_unpack_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (up_reg != UP_IDLE) |-> e_valid_reg)
        else $error("unpack running without a held operation");

    // The last request byte hands over to the receive phase.
    a_last_to_recv: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_fin && has_res && (res.result_kind == RK_TX) && res.last_byte)
        |=> (phase_reg == PH_RECV))
        else $error("last request byte did not enter receive phase");

    // The valid response length never exceeds the buffer.
    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= 8'(BUF_WORDS))
        else $error("response length beyond buffer");

    // Each accepted operation occupies the execute stage, so the channel is not ready after acceptance.
    a_two_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("operation accepted while execute stage busy");

endmodule
